// ===== hw/rtl/threshold_local_max_3x3_defines.svh =====
// Assertion macros used by the checker file of threshold_local_max_3x3.
`ifndef THRESHOLD_LOCAL_MAX_3X3_DEFINES_SVH
`define THRESHOLD_LOCAL_MAX_3X3_DEFINES_SVH

// same-cycle implication
`define TLM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tlm_pkg.sv =====
// Package: shared constants and codes of the 3x3 peak detector.
`default_nettype none

package tlm_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_VALUE_BITS = 24;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;

    localparam int FW_BITS     = 12;
    localparam int FH_BITS     = 13;
    localparam int IN_ROW_BITS = 13;
    localparam int ROW_BITS    = 12;

    localparam int MIN_SIZE     = 3;
    localparam int MAX_HEIGHT   = 4096;
    localparam int RST_WIDTH    = 640;
    localparam int RST_HEIGHT   = 480;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_THRESHOLD    = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_FLUSH = 1'b1
    } action_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlm_line_mem.sv =====
// Line store: one-write one-read memory, registered read, write bypass.
`default_nettype none

module tlm_line_mem #(
    parameter int DEPTH     = 2048,
    parameter int DATA_BITS = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [DATA_BITS-1:0]         wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [DATA_BITS-1:0]         rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] mem_q_reg;
    logic [DATA_BITS-1:0] byp_data_reg;
    logic                 byp_sel_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_sel_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_sel_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_sel_reg ? byp_data_reg : mem_q_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/threshold_local_max_3x3.sv =====
// Top level: thresholded 3x3 non-maximum suppression on a raster stream.
//
// Input channel (in_valid/in_ready): one pixel or flush tick per transfer,
// raster order. A pixel's decision comes out frame_width+1 items later, so
// frame_width+1 flush ticks drain the frame after its last pixel; the next
// item then starts a new frame. Output channel (out_valid/out_ready): zero
// or one result per input item, in raster order, last_of_frame on the
// frame's final pixel.
// Throughput: one item per cycle while the output does not stall. The line
// store has one read and one write port; each item reads its column at
// transfer and writes it back as it leaves stage 1; that port pair sets the
// rate. A deciding item is held in stage 1, and its result is then held in
// the output register. When out_ready is low the output register holds
// its result, the one item behind it waits, and in_ready drops; nothing is
// lost. Reset clears counters, window and handshake state; threshold 0,
// width 640, height 480. The line store is not cleared. Configuration
// (cfg_valid, cfg_index, cfg_data) is always ready; the user must write it
// only while the block idles, and the block itself does not enforce this.
`default_nettype none

module threshold_local_max_3x3 #(
    parameter int MAX_WIDTH  = tlm_pkg::DEF_MAX_WIDTH,
    parameter int VALUE_BITS = tlm_pkg::DEF_VALUE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tlm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tlm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic signed [VALUE_BITS-1:0]        pixel_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                is_peak,
    output logic [$clog2(MAX_WIDTH)-1:0]        out_col,
    output logic [tlm_pkg::ROW_BITS-1:0]        out_row,
    output logic                                last_of_frame
);

    import tlm_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int WN_BITS  = $clog2(MAX_WIDTH + 1);
    localparam int W_BITS   = (WN_BITS > FW_BITS) ? WN_BITS : FW_BITS;
    localparam int TW       = (VALUE_BITS > CFG_DATA_BITS) ? VALUE_BITS : CFG_DATA_BITS;

    typedef struct packed {
        logic has_dec;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } judge_ctrl_t;

    // configuration
    logic signed [VALUE_BITS-1:0] threshold_reg;
    logic [FW_BITS-1:0]           frame_width_reg;
    logic [FH_BITS-1:0]           frame_height_reg;
    logic [TW-1:0]                cfg_wide;

    assign cfg_ready = 1'b1;
    assign cfg_wide  = TW'(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= '0;
            frame_width_reg  <= FW_BITS'(RST_WIDTH);
            frame_height_reg <= FH_BITS'(RST_HEIGHT);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_THRESHOLD:    threshold_reg    <= cfg_wide[VALUE_BITS-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // clamped frame size
    logic [W_BITS-1:0]  fw_ext;
    logic [W_BITS-1:0]  w_eff;
    logic [FH_BITS-1:0] h_eff;
    logic [FH_BITS-1:0] h_p1;
    logic [FH_BITS-1:0] h_p2;

    assign fw_ext = W_BITS'(frame_width_reg);

    always_comb
    begin
        if (fw_ext < W_BITS'(MIN_SIZE))
            w_eff = W_BITS'(MIN_SIZE);
        else if (fw_ext > W_BITS'(MAX_WIDTH))
            w_eff = W_BITS'(MAX_WIDTH);
        else
            w_eff = fw_ext;

        if (frame_height_reg < FH_BITS'(MIN_SIZE))
            h_eff = FH_BITS'(MIN_SIZE);
        else if (frame_height_reg > FH_BITS'(MAX_HEIGHT))
            h_eff = FH_BITS'(MAX_HEIGHT);
        else
            h_eff = frame_height_reg;
    end

    assign h_p1 = h_eff + FH_BITS'(1);
    assign h_p2 = h_eff + FH_BITS'(2);

    // handshake
    logic s1_valid_reg;
    logic out_valid_reg;
    logic commit;
    logic accept;

    assign commit   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || commit;
    assign accept   = in_valid && in_ready;

    // stage 0: position counters, decision flags, line read
    logic [COL_BITS-1:0]    in_col_reg;
    logic [COL_BITS-1:0]    in_col_next;
    logic [IN_ROW_BITS-1:0] in_row_reg;
    logic [IN_ROW_BITS-1:0] in_row_next;
    logic [W_BITS-1:0]      c_inc;
    logic                   dec_a;
    logic                   dec_b;
    judge_ctrl_t            s0_ctrl;
    logic [COL_BITS-1:0]    s0_ocol;
    logic [IN_ROW_BITS-1:0] s0_row_dec;
    logic signed [VALUE_BITS-1:0] s0_val;
    logic [W_BITS-1:0]      w_m1;

    assign c_inc = W_BITS'(in_col_reg) + W_BITS'(1);
    assign w_m1  = w_eff - W_BITS'(1);

    always_comb
    begin
        // column zero finishes the last pixel of the row two above
        dec_a = (in_col_reg == '0) && (in_row_reg >= IN_ROW_BITS'(2))
                && (in_row_reg < h_p2);
        dec_b = (in_col_reg != '0) && (W_BITS'(in_col_reg) < w_eff)
                && (in_row_reg >= IN_ROW_BITS'(1)) && (in_row_reg < h_p1);

        s0_ctrl.has_dec  = dec_a || dec_b;
        s0_ctrl.right_ok = dec_b;
        s0_ctrl.left_ok  = dec_a || (in_col_reg >= COL_BITS'(2));
        s0_ctrl.top_ok   = dec_a ? (in_row_reg >= IN_ROW_BITS'(3))
                                 : (in_row_reg >= IN_ROW_BITS'(2));
        s0_ctrl.bot_ok   = dec_a ? (in_row_reg <= h_eff) : (in_row_reg < h_eff);
        s0_ctrl.last     = dec_a && (in_row_reg == h_p1);

        s0_ocol    = dec_a ? w_m1[COL_BITS-1:0] : (in_col_reg - COL_BITS'(1));
        s0_row_dec = dec_a ? (in_row_reg - IN_ROW_BITS'(2))
                           : (in_row_reg - IN_ROW_BITS'(1));

        s0_val = ((action == ACT_PIXEL) && (in_row_reg < h_eff)) ? pixel_value : '0;

        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        if (accept)
        begin
            if ((in_col_reg == '0) && (in_row_reg >= h_p1))
            begin
                in_col_next = '0;
                in_row_next = '0;
            end
            else if (c_inc >= w_eff)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + IN_ROW_BITS'(1);
            end
            else
            begin
                in_col_next = c_inc[COL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
        end
        else
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
        end
    end

    // stage 1 registers
    logic [COL_BITS-1:0]          s1_col_reg;
    logic signed [VALUE_BITS-1:0] s1_val_reg;
    judge_ctrl_t                  s1_ctrl_reg;
    logic [COL_BITS-1:0]          s1_ocol_reg;
    logic [ROW_BITS-1:0]          s1_orow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_ctrl_reg  <= '0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            s1_ctrl_reg  <= s0_ctrl;
        end
        else if (commit)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg  <= in_col_reg;
            s1_val_reg  <= s0_val;
            s1_ocol_reg <= s0_ocol;
            s1_orow_reg <= s0_row_dec[ROW_BITS-1:0];
        end
    end

    // line store: {upper, middle} per column
    logic [2*VALUE_BITS-1:0]      line_rd;
    logic signed [VALUE_BITS-1:0] up_new;
    logic signed [VALUE_BITS-1:0] mid_new;

    tlm_line_mem #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (2*VALUE_BITS)
    ) u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (commit),
        .wr_addr (s1_col_reg),
        .wr_data ({mid_new, s1_val_reg}),
        .rd_en   (accept),
        .rd_addr (in_col_reg),
        .rd_data (line_rd)
    );

    assign up_new  = line_rd[2*VALUE_BITS-1:VALUE_BITS];
    assign mid_new = line_rd[VALUE_BITS-1:0];

    // 3x3 window, rows by columns; the center is always column 2 before shift
    logic signed [VALUE_BITS-1:0] win_reg [3][3];
    logic signed [VALUE_BITS-1:0] center;
    logic                         sup_left;
    logic                         sup_mid;
    logic                         sup_right;
    logic                         peak;

    assign center = win_reg[1][2];

    always_comb
    begin
        sup_left  = (s1_ctrl_reg.top_ok && (win_reg[0][1] > center))
                    || (win_reg[1][1] > center)
                    || (s1_ctrl_reg.bot_ok && (win_reg[2][1] > center));
        sup_mid   = (s1_ctrl_reg.top_ok && (win_reg[0][2] > center))
                    || (s1_ctrl_reg.bot_ok && (win_reg[2][2] > center));
        sup_right = (s1_ctrl_reg.top_ok && (up_new > center))
                    || (mid_new > center)
                    || (s1_ctrl_reg.bot_ok && (s1_val_reg > center));
        peak = !(center < threshold_reg)
               && !(s1_ctrl_reg.left_ok && sup_left)
               && !sup_mid
               && !(s1_ctrl_reg.right_ok && sup_right);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (commit)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= up_new;
            win_reg[1][2] <= mid_new;
            win_reg[2][2] <= s1_val_reg;
        end
    end

    // output register
    logic                is_peak_reg;
    logic [COL_BITS-1:0] out_col_reg;
    logic [ROW_BITS-1:0] out_row_reg;
    logic                last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit && s1_ctrl_reg.has_dec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && s1_ctrl_reg.has_dec)
        begin
            is_peak_reg <= peak;
            out_col_reg <= s1_ocol_reg;
            out_row_reg <= s1_orow_reg;
            last_reg    <= s1_ctrl_reg.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_peak       = is_peak_reg;
    assign out_col       = out_col_reg;
    assign out_row       = out_row_reg;
    assign last_of_frame = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tlm_checker.sv =====
// Port-level checker for threshold_local_max_3x3 and its bind.
`default_nettype none

`include "threshold_local_max_3x3_defines.svh"

module tlm_checker #(
    parameter int MAX_WIDTH  = tlm_pkg::DEF_MAX_WIDTH,
    parameter int VALUE_BITS = tlm_pkg::DEF_VALUE_BITS
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [tlm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input logic [tlm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                action,
    input logic signed [VALUE_BITS-1:0]        pixel_value,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic                                is_peak,
    input logic [$clog2(MAX_WIDTH)-1:0]        out_col,
    input logic [tlm_pkg::ROW_BITS-1:0]        out_row,
    input logic                                last_of_frame
);

    import tlm_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);

    // stalled result holds
    `TLM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(is_peak) && $stable(out_col) && $stable(out_row) && $stable(last_of_frame), "stalled result changed")

    // input never blocked while the output side can move
    `TLM_ASSERT_IMP(a_in_flow, clk, rst_n, !out_valid || out_ready, in_ready, "input stalled with free output")

    // frame is at least 3x3, so its last pixel sits at row and column 2 or more
    `TLM_ASSERT_IMP(a_last_pos, clk, rst_n, out_valid && last_of_frame, (out_row >= ROW_BITS'(2)) && (out_col >= COL_BITS'(2)), "last_of_frame at impossible position")

    // the result after a frame's last is the next frame's first pixel
    `TLM_ASSERT_NXT(a_new_frame, clk, rst_n, out_valid && out_ready && last_of_frame, !out_valid || ((out_row == '0) && (out_col == '0)), "frame did not restart at origin")

endmodule

bind threshold_local_max_3x3 tlm_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .VALUE_BITS (VALUE_BITS)
) u_tlm_checker (.*);

`default_nettype wire
